// File: sv/hldr_pkg.sv
// types, constants and arithmetic helpers for the hourly light dimmer
`timescale 1ns / 1ps
package hldr_pkg;

    localparam int TABLE_SLOTS = 24;
    localparam int RAMP_STEPS  = 100;
    localparam int ADDR_W      = 5;
    localparam int LEVEL_W     = 7;
    localparam int ACC_W       = 15;

    localparam logic [ADDR_W-1:0]  LAST_HOUR  = 5'd23;
    localparam logic [LEVEL_W-1:0] DOOR_LEVEL = 7'd50;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;

    // x / 100 as (x * 5243) >> 19, exact for x below 2^15
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;
    localparam int DUTY_LIN_MUL = 255 * RECIP_100;
    localparam int DUTY_INV_MUL = 158 * RECIP_100;

    localparam logic [1:0] REG_PWM_CURVE       = 2'd0;
    localparam logic [1:0] REG_SMOOTH_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SCHED_INTERVAL  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_DOOR  = 2'd3
    } func_t;

    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        level_t            data;
    } tbl_req_t;

    // signed quotient of a by 100, cut toward zero
    function automatic logic [7:0] div100(input logic [ACC_W-1:0] a);
        logic [ACC_W-1:0] mag;
        logic [26:0]      prod;
        logic [7:0]       q;
        mag  = a[ACC_W-1] ? (~a + 15'd1) : a;
        prod = 27'(mag[ACC_W-2:0]) * 27'(RECIP_100);
        q    = {1'b0, prod[RECIP_SHIFT +: LEVEL_W]};
        return a[ACC_W-1] ? (~q + 8'd1) : q;
    endfunction

    function automatic logic [7:0] duty_of(input logic curve, input level_t level);
        logic [27:0] prod;
        if (!curve)
        begin
            prod = 28'(level) * 28'(DUTY_LIN_MUL);
        end
        else if (level > FULL_LEVEL)
        begin
            prod = '0;
        end
        else
        begin
            prod = 28'(FULL_LEVEL - level) * 28'(DUTY_INV_MUL);
        end
        return prod[RECIP_SHIFT +: 8];
    endfunction

endpackage

// File: sv/hldr_if.sv
// handshake channel interfaces for the hourly light dimmer
`timescale 1ns / 1ps
interface hldr_in_if;
    import hldr_pkg::*;
    logic        valid;
    logic        ready;
    func_t       func;
    logic [4:0]  hour;
    logic        clock_valid;
    logic [7:0]  value;
    modport source (output valid, func, hour, clock_valid, value, input ready);
    modport sink (input valid, func, hour, clock_valid, value, output ready);
endinterface

interface hldr_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  intensity;
    logic [7:0]  pwm_duty;
    logic        ballast_on;
    logic [6:0]  ramp_target;
    logic [6:0]  ramp_step;
    logic [6:0]  entry_value;
    logic        status;
    modport source (output valid, intensity, pwm_duty, ballast_on, ramp_target, ramp_step,
                    entry_value, status, input ready);
    modport sink (input valid, intensity, pwm_duty, ballast_on, ramp_target, ramp_step,
                  entry_value, status, output ready);
endinterface

interface hldr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/hldr_table.sv
// hourly intensity memory with per-entry written flags and registered read
`timescale 1ns / 1ps
module hldr_table
(
    input  logic                clk,
    input  logic                rst_n,
    input  hldr_pkg::tbl_req_t  req,
    output hldr_pkg::level_t    rd_data,
    output logic                rd_hit
);
    import hldr_pkg::*;

    level_t                 mem [0:TABLE_SLOTS-1];
    logic [TABLE_SLOTS-1:0] written_reg;
    level_t                 rd_data_reg;
    logic                   rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= written_reg[req.addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

// File: sv/hourly_light_dimmer_with_ramp_unit.sv
// Hourly light dimmer with linear ramp. Items are taken at one per cycle with no gaps while the
// result side is ready; a stalled output holds stage one and so the input. Each item is
// registered and the hour table read through the registered memory port at acceptance; the
// state update and the output register are then taken together when stage one advances. The
// table's written flags clear at reset, so there is no clearing pass and items are accepted from
// the first cycle after reset. Configuration is always ready.
`timescale 1ns / 1ps
module hourly_light_dimmer_with_ramp_unit
(
    input  logic        clk,
    input  logic        rst_n,
    hldr_in_if.sink     item,
    hldr_out_if.source  result,
    hldr_cfg_if.sink    cfg
);
    import hldr_pkg::*;

    // configuration
    logic        curve_reg;
    logic [31:0] smooth_int_reg;
    logic [31:0] sched_int_reg;

    // dimmer state
    level_t             level_reg, level_next;
    level_t             begin_reg, begin_next;
    level_t             end_reg, end_next;
    level_t             step_reg, step_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               doors_reg, doors_next;
    logic               relays_reg, relays_next;
    logic [31:0]        smooth_el_reg, smooth_el_next;
    logic [31:0]        sched_el_reg, sched_el_next;

    // stage one
    logic        s1_valid_reg;
    func_t       s1_func_reg;
    logic        s1_clock_valid_reg;
    logic        s1_range_reg;
    logic        s1_door_bit_reg;
    logic        s1_advance;
    logic        s1_hit;

    // output word
    logic        out_valid_reg;
    level_t      out_level_reg;
    logic        out_ballast_reg;
    level_t      out_target_reg;
    level_t      out_step_reg;
    level_t      out_entry_reg;
    logic        out_status_reg;
    level_t      entry_next;
    logic        status_next;

    tbl_req_t    tbl_req;
    level_t      tbl_rd_data;
    logic        tbl_rd_hit;
    logic        in_accept;
    logic        in_range;

    logic signed [7:0] ramp_diff;
    logic [7:0]        first_diff;
    logic [7:0]        ramp_level;
    logic              check;
    level_t            target;
    level_t            step_inc;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_advance;
    assign in_accept  = item.valid && item.ready;
    assign in_range   = (item.hour <= LAST_HOUR);
    assign s1_hit     = s1_range_reg && tbl_rd_hit;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        tbl_req.wr_en = in_accept && in_range && (item.func == FUNC_WRITE);
        tbl_req.rd_en = in_accept && in_range;
        tbl_req.addr  = item.hour;
        tbl_req.data  = (item.value > 8'(FULL_LEVEL)) ? FULL_LEVEL : item.value[LEVEL_W-1:0];
    end

    hldr_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd_data),
        .rd_hit  (tbl_rd_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_reg      <= 1'b1;
            smooth_int_reg <= 32'd100;
            sched_int_reg  <= 32'd1000;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_PWM_CURVE:       curve_reg      <= cfg.data[0];
                REG_SMOOTH_INTERVAL: smooth_int_reg <= cfg.data;
                REG_SCHED_INTERVAL:  sched_int_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg        <= item.func;
            s1_clock_valid_reg <= item.clock_valid;
            s1_range_reg       <= in_range;
            s1_door_bit_reg    <= item.value[0];
        end
        if (s1_advance)
        begin
            out_level_reg   <= level_next;
            out_ballast_reg <= relays_next;
            out_target_reg  <= end_next;
            out_step_reg    <= step_next;
            out_entry_reg   <= entry_next;
            out_status_reg  <= status_next;
        end
    end

    assign ramp_diff  = $signed({1'b0, end_reg}) - $signed({1'b0, begin_reg});
    assign ramp_level = {1'b0, begin_reg} +
                        div100(acc_reg + {{(ACC_W-8){ramp_diff[7]}}, ramp_diff});
    assign step_inc   = step_reg + 7'd1;

    always_comb
    begin
        level_next     = level_reg;
        begin_next     = begin_reg;
        end_next       = end_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        doors_next     = doors_reg;
        relays_next    = relays_reg;
        smooth_el_next = smooth_el_reg;
        sched_el_next  = sched_el_reg;
        check          = 1'b0;
        target         = '0;
        first_diff     = '0;
        entry_next     = '0;
        status_next    = 1'b0;
        if (s1_advance)
        begin
            unique case (s1_func_reg)
                FUNC_TICK:
                begin
                    if (smooth_el_reg != '1)
                    begin
                        smooth_el_next = smooth_el_reg + 32'd1;
                    end
                    if (sched_el_reg != '1)
                    begin
                        sched_el_next = sched_el_reg + 32'd1;
                    end
                    if (smooth_el_next >= smooth_int_reg && level_reg != end_reg)
                    begin
                        acc_next       = acc_reg + {{(ACC_W-8){ramp_diff[7]}}, ramp_diff};
                        level_next     = ramp_level[LEVEL_W-1:0];
                        step_next      = step_inc;
                        smooth_el_next = '0;
                        if (step_inc >= 7'(RAMP_STEPS))
                        begin
                            step_next  = '0;
                            acc_next   = '0;
                            level_next = end_reg;
                        end
                    end
                    if (sched_el_next >= sched_int_reg)
                    begin
                        sched_el_next = '0;
                        check         = 1'b1;
                    end
                end
                FUNC_WRITE:
                begin
                    status_next = !s1_range_reg;
                end
                FUNC_READ:
                begin
                    status_next = !s1_range_reg;
                    entry_next  = s1_hit ? tbl_rd_data : '0;
                end
                FUNC_DOOR:
                begin
                    doors_next = s1_door_bit_reg;
                    check      = 1'b1;
                end
                default: ;
            endcase

            if (check)
            begin
                if (doors_next)
                begin
                    target = DOOR_LEVEL;
                end
                else
                begin
                    target      = (s1_clock_valid_reg && s1_hit) ? tbl_rd_data : '0;
                    relays_next = (target != '0);
                end
                if (target != level_next && target != end_next)
                begin
                    begin_next = level_next;
                    end_next   = target;
                    step_next  = '0;
                    acc_next   = '0;
                    // first step of a fresh ramp moves only for a full-scale swing
                    if (smooth_el_next >= smooth_int_reg)
                    begin
                        first_diff     = {1'b0, target} - {1'b0, level_next};
                        step_next      = 7'd1;
                        acc_next       = {{(ACC_W-8){first_diff[7]}}, first_diff};
                        smooth_el_next = '0;
                        if (first_diff == 8'(RAMP_STEPS))
                        begin
                            level_next = level_next + 7'd1;
                        end
                        else if (first_diff == 8'(-RAMP_STEPS))
                        begin
                            level_next = level_next - 7'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            begin_reg     <= '0;
            end_reg       <= '0;
            step_reg      <= '0;
            acc_reg       <= '0;
            doors_reg     <= 1'b0;
            relays_reg    <= 1'b0;
            smooth_el_reg <= '0;
            sched_el_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            begin_reg     <= begin_next;
            end_reg       <= end_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            doors_reg     <= doors_next;
            relays_reg    <= relays_next;
            smooth_el_reg <= smooth_el_next;
            sched_el_reg  <= sched_el_next;
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.intensity   = out_level_reg;
    assign result.pwm_duty    = duty_of(curve_reg, out_level_reg);
    assign result.ballast_on  = out_ballast_reg;
    assign result.ramp_target = out_target_reg;
    assign result.ramp_step   = out_step_reg;
    assign result.entry_value = out_entry_reg;
    assign result.status      = out_status_reg;

    // ramp accumulator always equals step count times ramp span
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg == ($signed({8'b0, step_reg}) * $signed({{(ACC_W-8){ramp_diff[7]}}, ramp_diff})))
        else $error("ramp accumulator out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < 7'(RAMP_STEPS))
        else $error("ramp step counter past end");

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FULL_LEVEL && end_reg <= FULL_LEVEL && begin_reg <= FULL_LEVEL)
        else $error("level above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("word lost between stage one and output");

endmodule
